FILE: src/rc4kg_pkg.sv
// rc4kg_pkg: widths, command codes and the state table request type
// shared by the keystream generator modules; no dependencies
package rc4kg_pkg;

  localparam int BYTE_W            = 8;
  localparam int TABLE_SIZE        = 256;
  localparam int LEN_W             = 9;
  localparam int DEF_MAX_KEY_BYTES = 256;
  localparam logic [LEN_W-1:0] DEF_KEY_LENGTH = 9'd16;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SCHED = 2'd1,
    FUNC_GEN   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
    logic              clear;
  } perm_req_t;

endpackage

FILE: src/rc4kg_perm_mem.sv
// rc4kg_perm_mem: 256-entry state table, one write and one registered read per cycle
// per-entry valid bits give the identity on reset or clear; depends on rc4kg_pkg
module rc4kg_perm_mem
  import rc4kg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  perm_req_t         req,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0]     mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld;
  logic [BYTE_W-1:0]     mem_q;
  logic [BYTE_W-1:0]     raddr_q;
  logic [BYTE_W-1:0]     wdata_q;
  logic                  vld_q;
  logic                  fwd_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    mem_q   <= mem[req.raddr];
    raddr_q <= req.raddr;
    wdata_q <= req.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (req.clear) begin
        vld <= '0;
      end else if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      vld_q <= vld[req.raddr] && !req.clear;
      fwd_q <= req.we && !req.clear && (req.waddr == req.raddr);
    end
  end

  // write in the same cycle as the read wins
  assign rdata = fwd_q ? wdata_q : (vld_q ? mem_q : raddr_q);

endmodule

FILE: src/rc4kg_key_mem.sv
// rc4kg_key_mem: key byte store, one write and one registered read per cycle
// no reset on contents; depends on rc4kg_pkg
module rc4kg_key_mem
  import rc4kg_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_KEY_BYTES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rc4_keystream_generator.sv
// rc4_keystream_generator: top level, command sequencer around the state table
// depends on rc4kg_pkg, rc4kg_perm_mem and rc4kg_key_mem
//
//   channel   signals                             handshake
//   command   func, key_index, key_byte           start && !busy
//   config    cfg_data                            cfg_we, no wait
//   result    keystream_byte                      keystream_valid, one cycle
//
// load writes the key byte on accept and stays in IDLE, as do unused commands;
// generate steps through GEN_J, GEN_T and GEN_OUT, set by the dependent reads
// of the state table through its single read port; GEN_OUT registers the word.
// schedule runs SCH_RD, SCH_ACC and SCH_WR per swap, then a final write-back.
// reset clears the table to the identity at once; key_length resets to 16.
// the receiver cannot stall, a result is shown for one cycle only.
module rc4_keystream_generator
  import rc4kg_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [7:0]        key_index,
  input  logic [7:0]        key_byte,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_data,
  output logic              keystream_valid,
  output logic [7:0]        keystream_byte
);

  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef enum logic [2:0] {
    IDLE, GEN_J, GEN_T, GEN_OUT, SCH_RD, SCH_ACC, SCH_WR, SCH_LAST
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] i, j, si, t, sn;
  logic [KW-1:0]     kpos, klen_last;
  logic              pend;
  logic [LEN_W-1:0]  key_length;
  logic [KW-1:0]     klen_last_next;

  perm_req_t         preq;
  logic [BYTE_W-1:0] prd;
  logic [BYTE_W-1:0] krd;
  logic              accept;
  logic              key_we;
  logic [BYTE_W-1:0] acc_sum;

  assign busy    = !(state == IDLE || state == GEN_OUT);
  assign accept  = start && !busy;
  assign key_we  = accept && (func == FUNC_LOAD) &&
                   ({1'b0, key_index} < LEN_W'(MAX_KEY_BYTES));
  assign acc_sum = j + prd + krd;

  always_comb begin
    if (key_length <= LEN_W'(1)) begin
      klen_last_next = '0;
    end else if (key_length > LEN_W'(MAX_KEY_BYTES)) begin
      klen_last_next = KW'(MAX_KEY_BYTES - 1);
    end else begin
      klen_last_next = KW'(key_length - LEN_W'(1));
    end
  end

  always_comb begin
    preq.we    = 1'b0;
    preq.waddr = j;
    preq.wdata = si;
    preq.raddr = i + 8'd1;
    preq.clear = accept && (func == FUNC_SCHED);
    case (state)
      GEN_J: begin
        preq.raddr = j + prd;
      end
      GEN_T: begin
        preq.we    = 1'b1;
        preq.waddr = i;
        preq.wdata = prd;
        preq.raddr = si + prd;
      end
      GEN_OUT: begin
        preq.we = 1'b1;
      end
      SCH_RD: begin
        preq.we    = pend;
        preq.wdata = sn;
        preq.raddr = i;
      end
      SCH_ACC: begin
        preq.raddr = acc_sum;
      end
      SCH_WR: begin
        preq.we    = 1'b1;
        preq.waddr = i;
        preq.wdata = prd;
      end
      SCH_LAST: begin
        preq.we    = 1'b1;
        preq.wdata = sn;
      end
      default: begin
        preq.we = 1'b0;
      end
    endcase
  end

  rc4kg_perm_mem u_perm (
    .clk   (clk),
    .rst   (rst),
    .req   (preq),
    .rdata (prd)
  );

  rc4kg_key_mem #(
    .DEPTH (MAX_KEY_BYTES),
    .AW    (KW)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_index[KW-1:0]),
    .wdata (key_byte),
    .raddr (kpos),
    .rdata (krd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      i               <= '0;
      j               <= '0;
      pend            <= 1'b0;
      kpos            <= '0;
      klen_last       <= '0;
      key_length      <= DEF_KEY_LENGTH;
      keystream_valid <= 1'b0;
    end else begin
      keystream_valid <= (state == GEN_OUT);
      if (cfg_we) begin
        key_length <= cfg_data;
      end
      case (state)
        GEN_J: begin
          si    <= prd;
          j     <= j + prd;
          state <= GEN_T;
        end
        GEN_T: begin
          t     <= si + prd;
          state <= GEN_OUT;
        end
        SCH_RD: begin
          state <= SCH_ACC;
        end
        SCH_ACC: begin
          sn    <= prd;
          j     <= acc_sum;
          kpos  <= (kpos == klen_last) ? '0 : kpos + KW'(1);
          state <= SCH_WR;
        end
        SCH_WR: begin
          pend  <= 1'b1;
          i     <= i + 8'd1;
          state <= (i == 8'(TABLE_SIZE - 1)) ? SCH_LAST : SCH_RD;
        end
        SCH_LAST: begin
          j     <= '0;
          pend  <= 1'b0;
          state <= IDLE;
        end
        default: begin
          if (accept) begin
            case (func)
              FUNC_GEN: begin
                i     <= i + 8'd1;
                state <= GEN_J;
              end
              FUNC_SCHED: begin
                i         <= '0;
                j         <= '0;
                pend      <= 1'b0;
                kpos      <= '0;
                klen_last <= klen_last_next;
                state     <= SCH_RD;
              end
              default: begin
                state <= IDLE;
              end
            endcase
          end else begin
            state <= IDLE;
          end
        end
      endcase
      if (state == GEN_OUT) begin
        // entry j was rewritten this cycle with si
        keystream_byte <= (t == j) ? si : prd;
      end
    end
  end

endmodule
